// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst, prop, msg)

`define ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

// ===== hdl/lpnd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpnd_pkg
// Types and fixed constants of the nearest projected depth unit.
// ----------------------------------------------------------------------------
package lpnd_pkg;

   localparam int COORD_W   = 16;
   localparam int QUERY_W   = 16;
   localparam int CFG_W     = 20;
   localparam int LIM_W     = 15;
   localparam int DEPTH_W   = 15;
   localparam int NUM_W     = 38;
   localparam int PIX_W     = 22;
   localparam int DIST_W    = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CNT_W     = 5;

   localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(COORD_W);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PIX_W);

   localparam logic [COORD_W:0] MIN_DEPTH_MM = 17'd100;

   localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
   localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
   localparam logic [DIST_W-1:0]       DIST_MAX = {DIST_W{1'b1}};

   localparam logic [CFG_W-1:0] FOCAL_X_RST  = 20'd36524;
   localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 20'd36618;
   localparam logic [CFG_W-1:0] CENTER_X_RST = 20'd15465;
   localparam logic [CFG_W-1:0] CENTER_Y_RST = 20'd8317;
   localparam logic [LIM_W-1:0] NEAR_RST     = 15'd300;
   localparam logic [LIM_W-1:0] FAR_RST      = 15'd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOCAL_X  = 3'd0,
      REG_FOCAL_Y  = 3'd1,
      REG_CENTER_X = 3'd2,
      REG_CENTER_Y = 3'd3,
      REG_NEAR     = 3'd4,
      REG_FAR      = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SQR,
      ST_CMP,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } ser_ctl_type;

endpackage

// ===== hdl/lidar_pixel_nearest_depth_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_pixel_nearest_depth_unit
// Projects lidar points through a pinhole model and keeps the forward depth
// of the point nearest to a query pixel; reports it at the end of each pass.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Contents
//   req_      in         req_valid / req_stall  point, query pixel, last mark
//   rsp_      out        rsp_valid / rsp_stall  found flag, depth in mm
//   csr_      in         csr_wr_en              register index, write data
//
// A point inside the range window passes from acceptance through the serial
// multiply, the divider load, the serial divide, squaring, compare and finish
// before the next one can be taken; a skipped point goes straight to finish.
// One result is held in an output register; a last point waits in its final
// cycle only while that register is still full and stalled.
// Reset is synchronous and restores the registers and clears the pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_pixel_nearest_depth_unit
   import lpnd_pkg::*;
#(
   parameter int FRAC_BITS = 4
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_W-1:0]   req_point_fwd,
   input  logic signed [COORD_W-1:0]   req_point_left,
   input  logic signed [COORD_W-1:0]   req_point_up,
   input  logic [QUERY_W-1:0]          req_query_col,
   input  logic [QUERY_W-1:0]          req_query_row,
   input  logic                        req_last_point,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [DEPTH_W-1:0]          rsp_depth_mm,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_wdata
);

   localparam int DEN_W = LIM_W + FRAC_BITS;
   localparam int SQ_W  = 2 * (PIX_W + FRAC_BITS);
   localparam int SUM_W = SQ_W + 1;
   localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

   logic [CFG_W-1:0]          focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [LIM_W-1:0]          near_ff, far_ff;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic [COORD_W-1:0]        fwd_ff;
   logic [QUERY_W-1:0]        qcol_ff, qrow_ff;
   logic                      last_ff;

   logic [DIST_W-1:0]         best_dist_ff, best_dist_in;
   logic [DEPTH_W-1:0]        near_depth_ff, near_depth_in;
   logic                      have_best_ff, have_best_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [DEPTH_W-1:0]        rsp_depth_ff, rsp_depth_in;

   logic                      req_accept;
   logic                      in_window;
   logic signed [COORD_W:0]   fwd_ext;
   ser_ctl_type               mac_ctl, div_ctl;
   logic                      sq_en;
   logic signed [NUM_W-1:0]   num_col, num_row;
   logic [DEN_W-1:0]          den;
   logic signed [PIX_W-1:0]   pix_col, pix_row;
   logic [SQ_W-1:0]           sq_col, sq_row;
   logic [EXT_W-1:0]          dist_sum;
   logic [DIST_W-1:0]         cand_dist;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      fwd_ext = {req_point_fwd[COORD_W-1], req_point_fwd};
      in_window = (fwd_ext >= $signed({2'b00, near_ff}))
               && (fwd_ext <= $signed({2'b00, far_ff}))
               && (fwd_ext >= $signed(MIN_DEPTH_MM));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= FOCAL_X_RST;
         focal_y_ff <= FOCAL_Y_RST;
         center_x_ff <= CENTER_X_RST;
         center_y_ff <= CENTER_Y_RST;
         near_ff <= NEAR_RST;
         far_ff <= FAR_RST;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_FOCAL_X: begin
               focal_x_ff <= csr_wdata;
            end
            REG_FOCAL_Y: begin
               focal_y_ff <= csr_wdata;
            end
            REG_CENTER_X: begin
               center_x_ff <= csr_wdata;
            end
            REG_CENTER_Y: begin
               center_y_ff <= csr_wdata;
            end
            REG_NEAR: begin
               near_ff <= csr_wdata[LIM_W-1:0];
            end
            REG_FAR: begin
               far_ff <= csr_wdata[LIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_ff <= req_point_fwd;
         qcol_ff <= req_query_col;
         qrow_ff <= req_query_row;
         last_ff <= req_last_point;
      end
   end

   lpnd_mac u_mac_col (
      .clock  (clock),
      .ctl    (mac_ctl),
      .fwd    (req_point_fwd),
      .lat    (req_point_left),
      .center (center_x_ff),
      .focal  (focal_x_ff),
      .num    (num_col)
   );

   lpnd_mac u_mac_row (
      .clock  (clock),
      .ctl    (mac_ctl),
      .fwd    (req_point_fwd),
      .lat    (req_point_up),
      .center (center_y_ff),
      .focal  (focal_y_ff),
      .num    (num_row)
   );

   assign den = DEN_W'(fwd_ff[DEPTH_W-1:0]) << FRAC_BITS;

   lpnd_div #(.DEN_W(DEN_W)) u_div_col (
      .clock (clock),
      .ctl   (div_ctl),
      .num   (num_col),
      .den   (den),
      .pix   (pix_col)
   );

   lpnd_div #(.DEN_W(DEN_W)) u_div_row (
      .clock (clock),
      .ctl   (div_ctl),
      .num   (num_row),
      .den   (den),
      .pix   (pix_row)
   );

   lpnd_sqd #(.FRAC_BITS(FRAC_BITS), .SQ_W(SQ_W)) u_sqd_col (
      .clock (clock),
      .en    (sq_en),
      .pix   (pix_col),
      .query (qcol_ff),
      .sq    (sq_col)
   );

   lpnd_sqd #(.FRAC_BITS(FRAC_BITS), .SQ_W(SQ_W)) u_sqd_row (
      .clock (clock),
      .en    (sq_en),
      .pix   (pix_row),
      .query (qrow_ff),
      .sq    (sq_row)
   );

   always_comb begin
      dist_sum = EXT_W'(sq_col) + EXT_W'(sq_row);
      if (dist_sum > EXT_W'(DIST_MAX)) begin
         cand_dist = DIST_MAX;
      end else begin
         cand_dist = dist_sum[DIST_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mac_ctl = '0;
      div_ctl = '0;
      sq_en = 1'b0;
      best_dist_in = best_dist_ff;
      near_depth_in = near_depth_ff;
      have_best_in = have_best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_depth_in = rsp_depth_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mac_ctl.load = 1'b1;
               cnt_in = MUL_STEPS - 1'b1;
               state_in = in_window ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            mac_ctl.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            div_ctl.load = 1'b1;
            cnt_in = DIV_STEPS - 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_ctl.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            sq_en = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!have_best_ff || (cand_dist < best_dist_ff)) begin
               best_dist_in = cand_dist;
               near_depth_in = fwd_ff[DEPTH_W-1:0];
               have_best_in = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_best_ff;
               rsp_depth_in = have_best_ff ? near_depth_ff : '0;
               best_dist_in = DIST_MAX;
               near_depth_in = '0;
               have_best_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         best_dist_ff <= DIST_MAX;
         near_depth_ff <= '0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
         rsp_depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         best_dist_ff <= best_dist_in;
         near_depth_ff <= near_depth_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_found_ff <= rsp_found_in;
         rsp_depth_ff <= rsp_depth_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_depth_mm = rsp_depth_ff;

   `ASSERT_CLK(a_not_found_zero_depth, clock, reset, (rsp_valid_ff && !rsp_found_ff) |-> (rsp_depth_ff == '0), "result without a point carries a nonzero depth")
   `ASSERT_CLK(a_skip_goes_to_finish, clock, reset, (req_accept && !in_window) |=> (state_ff == ST_FIN), "skipped point did not go straight to finish")
   `ASSERT_CLK(a_pass_cleared, clock, reset, (state_ff == ST_FIN && last_ff && !(rsp_valid_ff && rsp_stall)) |=> (!have_best_ff && rsp_valid_ff), "pass end did not emit and clear")
   `ASSERT_NEVER(a_empty_near_depth, clock, reset, !have_best_ff && (near_depth_ff != '0), "empty best holds a depth")

endmodule

// ===== hdl/lpnd_mac.sv =====
// ----------------------------------------------------------------------------
// lpnd_mac
// Bit-serial multiply-accumulate that forms center*fwd - focal*lat, one
// multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module lpnd_mac
   import lpnd_pkg::*;
(
   input  logic                       clock,
   input  ser_ctl_type                ctl,
   input  logic [COORD_W-1:0]         fwd,
   input  logic [COORD_W-1:0]         lat,
   input  logic [CFG_W-1:0]           center,
   input  logic [CFG_W-1:0]           focal,
   output logic signed [NUM_W-1:0]    num
);

   logic [COORD_W-1:0]      fwd_sh_ff, fwd_sh_in;
   logic [COORD_W-1:0]      lat_sh_ff, lat_sh_in;
   logic                    first_ff, first_in;
   logic [NUM_W-1:0]        acc_ff, acc_in;
   logic [NUM_W-1:0]        term_c;
   logic [NUM_W-1:0]        term_f;

   always_comb begin
      term_c = fwd_sh_ff[COORD_W-1] ? NUM_W'(center) : '0;
      term_f = lat_sh_ff[COORD_W-1] ? NUM_W'(focal) : '0;
      fwd_sh_in = fwd_sh_ff;
      lat_sh_in = lat_sh_ff;
      first_in = first_ff;
      acc_in = acc_ff;
      if (ctl.load) begin
         fwd_sh_in = fwd;
         lat_sh_in = lat;
         first_in = 1'b1;
         acc_in = '0;
      end else if (ctl.step) begin
         fwd_sh_in = {fwd_sh_ff[COORD_W-2:0], 1'b0};
         lat_sh_in = {lat_sh_ff[COORD_W-2:0], 1'b0};
         first_in = 1'b0;
         // The sign bit of a two's complement multiplier carries negative weight.
         if (first_ff) begin
            acc_in = {acc_ff[NUM_W-2:0], 1'b0} + term_f - term_c;
         end else begin
            acc_in = {acc_ff[NUM_W-2:0], 1'b0} + term_c - term_f;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_sh_ff <= fwd_sh_in;
      lat_sh_ff <= lat_sh_in;
      first_ff <= first_in;
      acc_ff <= acc_in;
   end

   assign num = $signed(acc_ff);

endmodule

// ===== hdl/lpnd_div.sv =====
// ----------------------------------------------------------------------------
// lpnd_div
// Restoring bit-serial divider that yields the saturated whole pixel of a
// signed numerator over a positive denominator, truncated toward zero.
// ----------------------------------------------------------------------------
module lpnd_div
   import lpnd_pkg::*;
#(
   parameter int DEN_W = 19
)
(
   input  logic                       clock,
   input  ser_ctl_type                ctl,
   input  logic signed [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]           den,
   output logic signed [PIX_W-1:0]    pix
);

   localparam int REM_W = DEN_W + 1;

   logic [NUM_W-1:0]  mag;
   logic [REM_W-1:0]  den_ext;
   logic [REM_W-1:0]  shifted;
   logic              fits;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [PIX_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;

   always_comb begin
      mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_ext = REM_W'(den);
      shifted = {rem_ff[REM_W-2:0], quo_ff[PIX_W-1]};
      fits = shifted >= den_ext;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      if (ctl.load) begin
         rem_in = REM_W'(mag[NUM_W-2:PIX_W]);
         quo_in = mag[PIX_W-1:0];
         neg_in = num[NUM_W-1];
         ovf_in = REM_W'(mag[NUM_W-2:PIX_W]) >= den_ext;
      end else if (ctl.step) begin
         rem_in = fits ? shifted - den_ext : shifted;
         quo_in = {quo_ff[PIX_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || (quo_ff[PIX_W-1] && (|quo_ff[PIX_W-2:0]))) begin
            pix = PIX_MIN;
         end else begin
            pix = $signed(PIX_W'(0) - quo_ff);
         end
      end else begin
         if (ovf_ff || quo_ff[PIX_W-1]) begin
            pix = PIX_MAX;
         end else begin
            pix = $signed(quo_ff);
         end
      end
   end

endmodule

// ===== hdl/lpnd_sqd.sv =====
// ----------------------------------------------------------------------------
// lpnd_sqd
// Squared distance along one axis between a projected pixel and the query,
// in fractional pixel units, registered.
// ----------------------------------------------------------------------------
module lpnd_sqd
   import lpnd_pkg::*;
#(
   parameter int FRAC_BITS = 4,
   parameter int SQ_W = 52
)
(
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [PIX_W-1:0]    pix,
   input  logic [QUERY_W-1:0]         query,
   output logic [SQ_W-1:0]            sq
);

   localparam int D_W = PIX_W + FRAC_BITS + 1;
   localparam int A_W = D_W - 1;

   logic signed [D_W-1:0] pix_ext;
   logic signed [D_W-1:0] diff;
   logic [A_W-1:0]        mag;
   logic [SQ_W-1:0]       sq_ff, sq_in;

   always_comb begin
      pix_ext = D_W'(pix);
      diff = (pix_ext <<< FRAC_BITS) - $signed(D_W'(query));
      mag = diff[D_W-1] ? A_W'(-diff) : A_W'(diff);
      sq_in = SQ_W'(mag) * SQ_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

// ===== tb/lidar_pixel_nearest_depth_unit_test.sv =====
// ----------------------------------------------------------------------------
// lidar_pixel_nearest_depth_unit_test
// Sends passes of lidar points with a query pixel and predicts, for each pass,
// whether a point fell in the range window and the depth of the one projected
// nearest to the query. Results are compared in order against the prediction
// under several register settings, idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module lidar_pixel_nearest_depth_unit_test;
   import lpnd_pkg::*;

   localparam int FRAC_BITS    = 4;
   localparam int DRAIN_CYCLES = 60;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int PHASE_ITEMS  = 160;

   typedef struct {
      logic signed [COORD_W-1:0] fwd;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] up;
      logic [QUERY_W-1:0]        qcol;
      logic [QUERY_W-1:0]        qrow;
      logic                      last_point;
   } point_type;

   typedef struct {
      logic               found;
      logic [DEPTH_W-1:0] depth_mm;
   } depth_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_point_fwd;
   logic signed [COORD_W-1:0] req_point_left;
   logic signed [COORD_W-1:0] req_point_up;
   logic [QUERY_W-1:0]        req_query_col;
   logic [QUERY_W-1:0]        req_query_row;
   logic                      req_last_point;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_found;
   logic [DEPTH_W-1:0]        rsp_depth_mm;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CFG_W-1:0]          csr_wdata;

   logic [CFG_W-1:0] cfg_focal_x;
   logic [CFG_W-1:0] cfg_focal_y;
   logic [CFG_W-1:0] cfg_center_x;
   logic [CFG_W-1:0] cfg_center_y;
   logic [LIM_W-1:0] cfg_near_mm;
   logic [LIM_W-1:0] cfg_far_mm;

   longint unsigned best_sq_dist;
   logic [DEPTH_W-1:0] near_depth;
   logic have_best;

   depth_result_type expected_depths[$];
   int error_count = 0;
   int unsigned cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;

   lidar_pixel_nearest_depth_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_fwd  (req_point_fwd),
      .req_point_left (req_point_left),
      .req_point_up   (req_point_up),
      .req_query_col  (req_query_col),
      .req_query_row  (req_query_row),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_depth_mm   (rsp_depth_mm),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The hold-off count runs here so that a long output stall can overlap
   // with the sender still offering points.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
      end
      rsp_stall = (hold_left != 0) || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_results
      depth_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_depths.size() == 0) begin
            $error("unexpected transaction: found %0d depth_mm %0d", rsp_found, rsp_depth_mm);
            error_count++;
         end else begin
            want = expected_depths.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               error_count++;
            end
            if (rsp_depth_mm !== want.depth_mm) begin
               $error("depth_mm: expected %0d, actual %0d", want.depth_mm, rsp_depth_mm);
               error_count++;
            end
         end
      end
   end

   function automatic longint project_pixel(longint lat, longint fwd, longint focal,
                                            longint center);
      longint num;
      longint den;
      longint pix;
      num = -lat * focal + center * fwd;
      den = fwd * (longint'(1) << FRAC_BITS);
      pix = num / den;
      if (pix > longint'(PIX_MAX)) begin
         pix = longint'(PIX_MAX);
      end
      if (pix < longint'(PIX_MIN)) begin
         pix = longint'(PIX_MIN);
      end
      return pix;
   endfunction

   function automatic longint unsigned pixel_sq_offset(longint pix, longint query);
      longint d;
      d = pix * (longint'(1) << FRAC_BITS) - query;
      if (d < 0) begin
         d = -d;
      end
      return longint'(d) * longint'(d);
   endfunction

   task automatic clear_pass();
      best_sq_dist = longint'(DIST_MAX);
      near_depth = '0;
      have_best = 1'b0;
   endtask

   task automatic predict_nearest(input point_type p);
      longint fwd;
      longint col;
      longint row;
      longint unsigned cand_dist;
      depth_result_type res;
      fwd = p.fwd;
      if (fwd >= longint'(cfg_near_mm) && fwd <= longint'(cfg_far_mm) &&
          fwd >= longint'(MIN_DEPTH_MM)) begin
         col = project_pixel(p.left, fwd, cfg_focal_x, cfg_center_x);
         row = project_pixel(p.up, fwd, cfg_focal_y, cfg_center_y);
         cand_dist = pixel_sq_offset(col, p.qcol) + pixel_sq_offset(row, p.qrow);
         if (cand_dist > longint'(DIST_MAX)) begin
            cand_dist = longint'(DIST_MAX);
         end
         if (!have_best || cand_dist < best_sq_dist) begin
            best_sq_dist = cand_dist;
            near_depth = DEPTH_W'(fwd);
            have_best = 1'b1;
         end
      end
      if (p.last_point) begin
         res.found = have_best;
         res.depth_mm = have_best ? near_depth : '0;
         expected_depths.insert(expected_depths.size(), res);
         clear_pass();
      end
   endtask

   task automatic send_point(input point_type p);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_point_fwd = p.fwd;
      req_point_left = p.left;
      req_point_up = p.up;
      req_query_col = p.qcol;
      req_query_row = p.qrow;
      req_last_point = p.last_point;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_nearest(p);
   endtask

   task automatic send_fields(input int fwd, input int left, input int up, input int qcol,
                              input int qrow, input logic last_point);
      point_type p;
      p.fwd = COORD_W'(fwd);
      p.left = COORD_W'(left);
      p.up = COORD_W'(up);
      p.qcol = QUERY_W'(qcol);
      p.qrow = QUERY_W'(qrow);
      p.last_point = last_point;
      send_point(p);
   endtask

   task automatic drain_and_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_depths.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_FOCAL_X:  cfg_focal_x = value;
         REG_FOCAL_Y:  cfg_focal_y = value;
         REG_CENTER_X: cfg_center_x = value;
         REG_CENTER_Y: cfg_center_y = value;
         REG_NEAR:     cfg_near_mm = LIM_W'(value);
         REG_FAR:      cfg_far_mm = LIM_W'(value);
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                            input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                            input logic [CFG_W-1:0] near_mm, input logic [CFG_W-1:0] far_mm);
      write_register(REG_FOCAL_X, fx);
      write_register(REG_FOCAL_Y, fy);
      write_register(REG_CENTER_X, cx);
      write_register(REG_CENTER_Y, cy);
      write_register(REG_NEAR, near_mm);
      write_register(REG_FAR, far_mm);
   endtask

   function automatic logic [CFG_W-1:0] pick_setting(int lo, int hi, int top);
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return '0;
      end
      if (r == 1) begin
         return CFG_W'(top);
      end
      return CFG_W'($urandom_range(hi, lo));
   endfunction

   function automatic point_type make_random_point();
      point_type p;
      int kind;
      int lo;
      int hi;
      int f;
      kind = $urandom_range(99);
      p.fwd = COORD_W'($urandom);
      p.left = COORD_W'($urandom);
      p.up = COORD_W'($urandom);
      lo = (cfg_near_mm > 100) ? int'(cfg_near_mm) : 100;
      hi = int'(cfg_far_mm);
      if (kind < 12) begin
         return p;
      end
      p.left = COORD_W'(int'($urandom_range(4000)) - 2000);
      p.up = COORD_W'(int'($urandom_range(4000)) - 2000);
      if (kind < 25 || lo > hi) begin
         case ($urandom_range(3))
            0: p.fwd = COORD_W'(-int'($urandom_range(32768, 1)));
            1: p.fwd = COORD_W'($urandom_range(99));
            2: p.fwd = (hi < 32767) ? COORD_W'($urandom_range(32767, hi + 1)) : 16'sh8000;
            default: p.fwd = (cfg_near_mm > 0) ? COORD_W'($urandom_range(cfg_near_mm - 1))
                                               : 16'sh8000;
         endcase
         return p;
      end
      if ($urandom_range(1) == 0 && lo + 3000 < hi) begin
         f = $urandom_range(lo + 3000, lo);
      end else begin
         f = $urandom_range(hi, lo);
      end
      p.fwd = COORD_W'(f);
      p.left = COORD_W'(int'($urandom_range(2 * f)) - f);
      p.up = COORD_W'(int'($urandom_range(2 * f)) - f);
      return p;
   endfunction

   function automatic logic [QUERY_W-1:0] pick_query(input logic [CFG_W-1:0] center);
      int r;
      int q;
      r = $urandom_range(99);
      if (r < 10) begin
         return ($urandom_range(1) == 0) ? '0 : '1;
      end
      if (r < 50) begin
         return QUERY_W'($urandom);
      end
      q = int'(center) + int'($urandom_range(16000)) - 8000;
      if (q < 0) begin
         q = 0;
      end
      if (q > 65535) begin
         q = 65535;
      end
      return QUERY_W'(q);
   endfunction

   task automatic send_random_pass(output int count);
      point_type p;
      point_type prev;
      logic [QUERY_W-1:0] qcol;
      logic [QUERY_W-1:0] qrow;
      count = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
      qcol = pick_query(cfg_center_x);
      qrow = pick_query(cfg_center_y);
      for (int i = 0; i < count; i++) begin
         p = make_random_point();
         if (i > 0 && $urandom_range(7) == 0 && prev.fwd >= 100 && prev.fwd <= 16383 &&
             prev.left >= -16384 && prev.left <= 16383 &&
             prev.up >= -16384 && prev.up <= 16383) begin
            p.fwd = COORD_W'(prev.fwd * 2);
            p.left = COORD_W'(prev.left * 2);
            p.up = COORD_W'(prev.up * 2);
         end
         p.qcol = qcol;
         p.qrow = qrow;
         p.last_point = (i == count - 1);
         send_point(p);
         prev = p;
      end
   endtask

   task automatic test_default_window();
      drain_and_idle();
      send_fields(-32768, 0, 0, 0, 0, 1'b0);
      send_fields(32767, 0, 0, 0, 0, 1'b0);
      send_fields(299, 0, 0, 0, 0, 1'b0);
      send_fields(10001, 0, 0, 0, 0, 1'b1);
      send_fields(300, 32767, -32768, 65535, 65535, 1'b0);
      send_fields(10000, -32768, 32767, 65535, 65535, 1'b0);
      send_fields(1000, 0, 0, 65535, 65535, 1'b1);
      send_fields(1000, 100, 50, 20000, 9000, 1'b0);
      send_fields(2000, 200, 100, 20000, 9000, 1'b1);
      send_fields(500, 400, 0, 15456, 8304, 1'b0);
      send_fields(800, 0, 0, 15456, 8304, 1'b1);
   endtask

   task automatic test_min_depth_and_overflow();
      drain_and_idle();
      write_all('1, '0, '0, '1, '0, 20'h7FFF);
      send_fields(0, 5, 5, 100, 100, 1'b0);
      send_fields(50, 0, 0, 100, 100, 1'b0);
      send_fields(99, -7, 7, 100, 100, 1'b1);
      send_fields(100, -32768, 32767, 65535, 0, 1'b0);
      send_fields(200, -32768, 0, 65535, 0, 1'b0);
      send_fields(32767, 32767, 0, 65535, 0, 1'b1);
   endtask

   task automatic test_crossed_window();
      drain_and_idle();
      write_register(REG_NEAR, 20'd5000);
      write_register(REG_FAR, 20'd4000);
      send_fields(4500, 10, 10, 30000, 30000, 1'b0);
      send_fields(4000, 0, 0, 30000, 30000, 1'b1);
   endtask

   task automatic test_output_backpressure();
      int count;
      drain_and_idle();
      write_all(FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST, CFG_W'(NEAR_RST),
                CFG_W'(FAR_RST));
      send_idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_left = 600;
      for (int i = 0; i < 8; i++) begin
         send_random_pass(count);
      end
   endtask

   task automatic test_random_passes();
      int sent;
      int count;
      for (int ph = 0; ph < 8; ph++) begin
         drain_and_idle();
         if (ph == 0) begin
            write_all(FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST, CFG_W'(NEAR_RST),
                      CFG_W'(FAR_RST));
         end else begin
            write_all(pick_setting(16000, 60000, 1048575), pick_setting(16000, 60000, 1048575),
                      pick_setting(0, 40000, 1048575), pick_setting(0, 40000, 1048575),
                      pick_setting(0, 800, 32767), pick_setting(2000, 32767, 32767));
         end
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 83;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 83;
            end
            default: begin
               send_idle_pct = 6;
               stall_pct = 6;
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_random_pass(count);
            sent += count;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_point_fwd = '0;
      req_point_left = '0;
      req_point_up = '0;
      req_query_col = '0;
      req_query_row = '0;
      req_last_point = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = REG_FOCAL_X;
      csr_wdata = '0;
      cfg_focal_x = FOCAL_X_RST;
      cfg_focal_y = FOCAL_Y_RST;
      cfg_center_x = CENTER_X_RST;
      cfg_center_y = CENTER_Y_RST;
      cfg_near_mm = NEAR_RST;
      cfg_far_mm = FAR_RST;
      clear_pass();
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_default_window();
      test_min_depth_and_overflow();
      test_crossed_window();
      test_output_backpressure();
      test_random_passes();
      drain_and_idle();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lpnd_pkg.sv
hdl/lpnd_mac.sv
hdl/lpnd_div.sv
hdl/lpnd_sqd.sv
hdl/lidar_pixel_nearest_depth_unit.sv
tb/lidar_pixel_nearest_depth_unit_test.sv
